>>> hdl/multi_led_blink_controller_macros.svh
// ---------------------------------------------------------------------------
// multi_led_blink_controller assertion macros
// concurrent checks clocked on clk, held off while arst_n is low
// ---------------------------------------------------------------------------
`ifndef MULTI_LED_BLINK_CONTROLLER_MACROS_SVH
`define MULTI_LED_BLINK_CONTROLLER_MACROS_SVH

// same-cycle implication
`define MLBC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MLBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mlbc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlbc_pkg
// shared types, codes and constants of the multi-set led blink controller
// ---------------------------------------------------------------------------
package mlbc_pkg;

	localparam int CMD_W        = 3;
	localparam int WORD_W       = 12;
	localparam int SET_ID_W     = 4;
	localparam int SET_ID_SPACE = 16;
	localparam int MODE_W       = 3;
	localparam int LED_W        = 6;
	localparam int PERIOD_W     = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int S_TDATA_W    = 16;
	localparam int M_TDATA_W    = 16;
	localparam int M_PAD_W      = M_TDATA_W - 1 - 2 * LED_W;

	localparam logic [PERIOD_W-1:0] SLOW_HALF_RST  = 16'd250;
	localparam logic [PERIOD_W-1:0] FAST_HALF_RST  = 16'd50;
	localparam logic [PERIOD_W-1:0] VSLOW_ON_RST   = 16'd500;
	localparam logic [PERIOD_W-1:0] VSLOW_OFF_RST  = 16'd1500;
	localparam logic [LED_W-1:0]    PRESENT_RST    = 6'h3f;
	localparam logic [LED_W-1:0]    SYNC_GROUP_RST = 6'h0f;

	localparam logic [1:0] MASK_GREEN = 2'b10;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 3'd0,
		CMD_SET_MODE = 3'd1,
		CMD_TOGGLE   = 3'd2,
		CMD_ALL_RED  = 3'd3,
		CMD_ALL_OFF  = 3'd4
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF   = 3'd0,
		MODE_ON    = 3'd1,
		MODE_SLOW  = 3'd2,
		MODE_FAST  = 3'd3,
		MODE_VSLOW = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		TMR_OFFLINE  = 2'd0,
		TMR_SLEEPING = 2'd1,
		TMR_RUNNING  = 2'd2
	} tmr_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLOW_HALF  = 3'd0,
		CFG_FAST_HALF  = 3'd1,
		CFG_VSLOW_ON   = 3'd2,
		CFG_VSLOW_OFF  = 3'd3,
		CFG_PRESENT    = 3'd4,
		CFG_SYNC_GROUP = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] slow_half;
		logic [PERIOD_W-1:0] fast_half;
		logic [PERIOD_W-1:0] vslow_on;
		logic [PERIOD_W-1:0] vslow_off;
		logic [LED_W-1:0]    present_mask;
		logic [LED_W-1:0]    sync_mask;
	} cfg_t;

	// decoded item broadcast to every set
	typedef struct packed {
		cmd_t                cmd;
		logic [MODE_W-1:0]   mode;
		logic [1:0]          mask;
		logic                id_ok;
	} op_t;

	function automatic logic is_blink(mode_t m);
		return (m == MODE_SLOW) || (m == MODE_FAST) || (m == MODE_VSLOW);
	endfunction

endpackage

>>> hdl/multi_led_blink_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_led_blink_controller
// red/green led sets with per-set blink timers driven by tick and command items
// ---------------------------------------------------------------------------
// The block takes one item per clock cycle, back to back, while the output does not stall,
// and returns exactly one result per item through the input register, then the
// result register. Every set updates its own mode, lit bits, phase and timer in
// parallel in one pass of short logic, so the only thing that sets the rate is the
// output side: when the result register is held by m_axis_tready low, one more
// item is still taken if the input register is empty, then the slave side stalls.
// The result shows the lit state after the item; bits of absent sets read zero.
// Configuration writes are taken at any cycle but are meant for idle periods.
// ---------------------------------------------------------------------------
module multi_led_blink_controller import mlbc_pkg::*; #(
	parameter int NUM_SETS   = 6,
	parameter int TIMER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// item input
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [11:0] setting_word, [15:12] zero
	input  logic [CMD_W-1:0]     s_axis_tuser,  // [2:0] cmd
	// result output
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // [0] status, [6:1] red_outputs,
	                                            // [12:7] green_outputs, [15:13] zero
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data
);

	// input stage
	logic                    valid_s1;
	logic [CMD_W-1:0]        cmd_s1;
	logic [WORD_W-1:0]       word_s1;

	// result stage
	logic                    out_valid_q;
	logic [M_TDATA_W-1:0]    out_data_q;

	logic                    advance;
	logic                    fire;

	cfg_t                    cfg;
	op_t                     op;
	logic [SET_ID_W-1:0]     set_id;
	logic [SET_ID_SPACE-1:0] present_ext;
	logic [SET_ID_SPACE-1:0] sync_ext;
	logic                    status_nxt;
	logic [NUM_SETS-1:0]     red_nxt;
	logic [NUM_SETS-1:0]     grn_nxt;
	logic [LED_W-1:0]        red_out;
	logic [LED_W-1:0]        grn_out;

	// register file, writes never stall
	assign cfg_ready = 1'b1;

	mlbc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the result register frees up when empty or when its transfer completes
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign fire          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			word_s1 <= s_axis_tdata[WORD_W-1:0];
		end
	end

	// decode the held item
	assign set_id      = word_s1[11:8];
	assign present_ext = SET_ID_SPACE'(cfg.present_mask);
	assign sync_ext    = SET_ID_SPACE'(cfg.sync_mask);

	assign op.cmd   = cmd_t'(cmd_s1);
	assign op.mode  = word_s1[4:2];
	assign op.mask  = word_s1[1:0];
	assign op.id_ok = (int'(set_id) < NUM_SETS) && present_ext[set_id];

	// only the per-set commands can name a bad set
	assign status_nxt = ((op.cmd == CMD_SET_MODE) || (op.cmd == CMD_TOGGLE)) && !op.id_ok;

	// one cell per set, all updated together when the item moves on
	for (genvar i = 0; i < NUM_SETS; i++) begin : g_set
		logic [1:0] lit;

		mlbc_set #(
			.TIMER_BITS (TIMER_BITS)
		) u_set (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (fire),
			.op      (op),
			.cfg     (cfg),
			.target  (op.id_ok && (set_id == SET_ID_W'(i))),
			.present (present_ext[i]),
			.in_sync (sync_ext[i]),
			.lit_nxt (lit)
		);

		assign red_nxt[i] = lit[0];
		assign grn_nxt[i] = lit[1];
	end

	// absent sets read dark
	assign red_out = LED_W'(SET_ID_SPACE'(red_nxt) & present_ext);
	assign grn_out = LED_W'(SET_ID_SPACE'(grn_nxt) & present_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {{M_PAD_W{1'b0}}, grn_out, red_out, status_nxt};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> hdl/mlbc_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlbc_cfg
// register file for blink periods, set presence and sync group
// ---------------------------------------------------------------------------
module mlbc_cfg import mlbc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [PERIOD_W-1:0]  wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_half    <= SLOW_HALF_RST;
			cfg_q.fast_half    <= FAST_HALF_RST;
			cfg_q.vslow_on     <= VSLOW_ON_RST;
			cfg_q.vslow_off    <= VSLOW_OFF_RST;
			cfg_q.present_mask <= PRESENT_RST;
			cfg_q.sync_mask    <= SYNC_GROUP_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_SLOW_HALF:  cfg_q.slow_half    <= wr_data;
				CFG_FAST_HALF:  cfg_q.fast_half    <= wr_data;
				CFG_VSLOW_ON:   cfg_q.vslow_on     <= wr_data;
				CFG_VSLOW_OFF:  cfg_q.vslow_off    <= wr_data;
				CFG_PRESENT:    cfg_q.present_mask <= wr_data[LED_W-1:0];
				CFG_SYNC_GROUP: cfg_q.sync_mask    <= wr_data[LED_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/mlbc_set.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlbc_set
// state and next-state logic of one red/green led set with its blink timer
// ---------------------------------------------------------------------------
module mlbc_set import mlbc_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  op_t        op,
	input  cfg_t       cfg,
	input  logic       target,
	input  logic       present,
	input  logic       in_sync,
	output logic [1:0] lit_nxt
);

	mode_t                 mode_q [2];
	mode_t                 mode_n [2];
	logic [1:0]            lit_q, lit_n;
	logic                  phase_q, phase_n;
	tmr_state_t            tst_q, tst_n;
	logic [TIMER_BITS-1:0] rem_q, rem_n;

	mode_t                 blink_mode;
	logic                  flip_ph;
	logic [1:0]            mask_eff;
	logic                  last_c;
	logic                  vsync_hit;

	assign flip_ph  = ~phase_q;
	// an empty mask means green for blink modes
	assign mask_eff = (op.mask == 2'b00) ? MASK_GREEN : op.mask;
	assign last_c   = mask_eff[1];
	assign vsync_hit = (op.cmd == CMD_SET_MODE) && op.id_ok && (op.mode == MODE_VSLOW) &&
		(target || (in_sync && (mode_q[last_c] == MODE_VSLOW)));

	always_comb begin
		mode_n[0]  = mode_q[0];
		mode_n[1]  = mode_q[1];
		lit_n      = lit_q;
		phase_n    = phase_q;
		tst_n      = tst_q;
		rem_n      = rem_q;
		blink_mode = MODE_SLOW;

		case (op.cmd)
			CMD_TICK: begin
				if (tst_q == TMR_RUNNING) begin
					if (rem_q <= TIMER_BITS'(1)) begin
						phase_n = flip_ph;
						for (int c = 0; c < 2; c++) begin
							if (is_blink(mode_q[c])) begin
								blink_mode = mode_q[c];
								lit_n[c]   = flip_ph;
							end
						end
						// green wins when both colors blink
						if (blink_mode == MODE_VSLOW) begin
							rem_n = flip_ph ? TIMER_BITS'(cfg.vslow_on) :
								TIMER_BITS'(cfg.vslow_off);
						end else if (blink_mode == MODE_FAST) begin
							rem_n = TIMER_BITS'(cfg.fast_half);
						end else begin
							rem_n = TIMER_BITS'(cfg.slow_half);
						end
					end else begin
						rem_n = rem_q - TIMER_BITS'(1);
					end
				end
			end
			CMD_SET_MODE: begin
				if (target) begin
					case (op.mode)
						MODE_OFF: begin
							mode_n[0] = MODE_OFF;
							mode_n[1] = MODE_OFF;
							lit_n     = 2'b00;
							if (tst_q == TMR_RUNNING) tst_n = TMR_SLEEPING;
						end
						MODE_ON: begin
							mode_n[0] = MODE_OFF;
							mode_n[1] = MODE_OFF;
							if (tst_q == TMR_RUNNING) tst_n = TMR_SLEEPING;
							for (int c = 0; c < 2; c++) begin
								if (op.mask[c]) begin
									mode_n[c] = MODE_ON;
									lit_n[c]  = 1'b1;
								end
							end
						end
						MODE_SLOW, MODE_FAST, MODE_VSLOW: begin
							lit_n = 2'b00;
							for (int c = 0; c < 2; c++) begin
								mode_n[c] = mask_eff[c] ? mode_t'(op.mode) : MODE_OFF;
							end
							tst_n = TMR_RUNNING;
							if (op.mode == MODE_FAST) begin
								rem_n = TIMER_BITS'(cfg.fast_half);
							end else if (op.mode == MODE_SLOW) begin
								rem_n = TIMER_BITS'(cfg.slow_half);
							end
						end
						default: ;
					endcase
				end
				// very slow start realigns the target and very slow sync members to the dark phase
				if (vsync_hit) begin
					phase_n = 1'b0;
					if (tst_n != TMR_OFFLINE) begin
						rem_n = TIMER_BITS'(cfg.vslow_off);
						tst_n = TMR_RUNNING;
					end
				end
			end
			CMD_TOGGLE: begin
				if (target) lit_n = lit_q ^ op.mask;
			end
			CMD_ALL_RED: begin
				if (present) begin
					mode_n[0] = MODE_ON;
					mode_n[1] = MODE_OFF;
					lit_n     = 2'b01;
				end
			end
			CMD_ALL_OFF: begin
				if (present) begin
					mode_n[0] = MODE_OFF;
					mode_n[1] = MODE_OFF;
					lit_n     = 2'b00;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q[0] <= MODE_OFF;
			mode_q[1] <= MODE_OFF;
			lit_q     <= 2'b00;
			phase_q   <= 1'b0;
			tst_q     <= TMR_OFFLINE;
			rem_q     <= '0;
		end else if (en) begin
			mode_q[0] <= mode_n[0];
			mode_q[1] <= mode_n[1];
			lit_q     <= lit_n;
			phase_q   <= phase_n;
			tst_q     <= tst_n;
			rem_q     <= rem_n;
		end
	end

	assign lit_nxt = lit_n;

endmodule

>>> hdl/mlbc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlbc_checker
// port-level checks of the led blink controller, bound to the top level
// ---------------------------------------------------------------------------
`include "multi_led_blink_controller_macros.svh"

module mlbc_checker import mlbc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	`MLBC_ASSERT_NEXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	`MLBC_ASSERT_NEXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
	`MLBC_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
	`MLBC_ASSERT_IMPL(a_result_from_item, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without input transfer")
	`MLBC_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[M_TDATA_W-1:M_TDATA_W-M_PAD_W] == '0, "nonzero pad bits")

endmodule

bind multi_led_blink_controller mlbc_checker u_mlbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/multi_led_blink_controller_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_led_blink_controller_tb
// checks the led blink controller against a cycle-free model of its sets
// every item transfer updates the model, which predicts the status bit and
// the red and green outputs; each result transfer is compared field by field
// with the oldest prediction
// directed opening, then randomized phases under different register settings,
// with bursty input and a stalling output side
// ---------------------------------------------------------------------------
module multi_led_blink_controller_tb;
	import mlbc_pkg::*;

	localparam int NUM_LED_SETS = 6;
	localparam int PIPE_LATENCY = 2;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int COLOR_RED    = 0;
	localparam int COLOR_GREEN  = 1;

	// codes past the decoded ones: no operation, no meaning
	localparam logic [CMD_W-1:0]  CMD_RSVD_LO  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

	localparam logic [1:0] MASK_NONE = 2'b00;
	localparam logic [1:0] MASK_RED  = 2'b01;
	localparam logic [1:0] MASK_BOTH = 2'b11;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] word;
	} led_item_t;

	// same bit order as m_axis_tdata[12:0]
	typedef struct packed {
		logic [LED_W-1:0] green;
		logic [LED_W-1:0] red;
		logic             status;
	} led_result_t;

	// model of all sets plus the queue of predicted outputs
	class blink_scoreboard;
		logic [PERIOD_W-1:0] slow_half, fast_half, vslow_on, vslow_off;
		logic [LED_W-1:0]    present_mask, sync_mask;
		mode_t               color_mode [NUM_LED_SETS][2];
		bit                  lit [NUM_LED_SETS][2];
		bit                  phase [NUM_LED_SETS];
		tmr_state_t          tstate [NUM_LED_SETS];
		logic [PERIOD_W-1:0] remaining [NUM_LED_SETS];
		led_result_t         expected_leds [$];
		int                  errors;

		function new();
			slow_half    = SLOW_HALF_RST;
			fast_half    = FAST_HALF_RST;
			vslow_on     = VSLOW_ON_RST;
			vslow_off    = VSLOW_OFF_RST;
			present_mask = PRESENT_RST;
			sync_mask    = SYNC_GROUP_RST;
			for (int s = 0; s < NUM_LED_SETS; s++) begin
				for (int c = 0; c < 2; c++) begin
					color_mode[s][c] = MODE_OFF;
					lit[s][c] = 1'b0;
				end
				phase[s] = 1'b0;
				tstate[s] = TMR_OFFLINE;
				remaining[s] = '0;
			end
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [PERIOD_W-1:0] val);
			case (idx)
				CFG_SLOW_HALF:  slow_half = val;
				CFG_FAST_HALF:  fast_half = val;
				CFG_VSLOW_ON:   vslow_on = val;
				CFG_VSLOW_OFF:  vslow_off = val;
				CFG_PRESENT:    present_mask = val[LED_W-1:0];
				CFG_SYNC_GROUP: sync_mask = val[LED_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_leds.size();
		endfunction

		function bit set_exists(int s);
			return (s < NUM_LED_SETS) ? present_mask[s] : 1'b0;
		endfunction

		function bit is_blinking(mode_t m);
			return (m == MODE_SLOW) || (m == MODE_FAST) || (m == MODE_VSLOW);
		endfunction

		function void arm_timer(int s, logic [PERIOD_W-1:0] ticks);
			remaining[s] = ticks;
			tstate[s] = TMR_RUNNING;
		endfunction

		// phase flips, blinking colors follow, reload from the last blinking color
		function void expire_timer(int s);
			mode_t m;
			m = MODE_SLOW;
			phase[s] ^= 1'b1;
			for (int c = 0; c < 2; c++) begin
				if (is_blinking(color_mode[s][c])) begin
					m = color_mode[s][c];
					lit[s][c] = phase[s];
				end
			end
			if (m == MODE_VSLOW)
				arm_timer(s, phase[s] ? vslow_on : vslow_off);
			else if (m == MODE_FAST)
				arm_timer(s, fast_half);
			else
				arm_timer(s, slow_half);
		endfunction

		function void go_dark(int s);
			for (int c = 0; c < 2; c++) begin
				color_mode[s][c] = MODE_OFF;
				lit[s][c] = 1'b0;
			end
		endfunction

		function void halt_blink(int s);
			color_mode[s][COLOR_RED] = MODE_OFF;
			color_mode[s][COLOR_GREEN] = MODE_OFF;
			if (tstate[s] == TMR_RUNNING)
				tstate[s] = TMR_SLEEPING;
		endfunction

		function void start_blinking(int id, logic [1:0] mask, mode_t m);
			int  last;
			bit  grp;
			last = COLOR_GREEN;
			if (mask == MASK_NONE)
				mask = MASK_GREEN;
			for (int c = 0; c < 2; c++) begin
				if (mask[c]) begin
					color_mode[id][c] = m;
					last = c;
				end
			end
			tstate[id] = TMR_RUNNING;
			if (m == MODE_VSLOW) begin
				// resync the group members blinking the same color very slowly
				for (int i = 0; i < NUM_LED_SETS; i++) begin
					grp = sync_mask[i] && (color_mode[i][last] == MODE_VSLOW);
					if (!grp && i != id)
						continue;
					phase[i] = 1'b0;
					if (tstate[i] == TMR_OFFLINE)
						continue;
					arm_timer(i, vslow_off);
				end
			end else begin
				arm_timer(id, (m == MODE_FAST) ? fast_half : slow_half);
			end
		endfunction

		function void note_item(led_item_t it);
			led_result_t         r;
			int                  id;
			logic [MODE_W-1:0]   mode;
			logic [1:0]          mask;
			bit                  ok;
			r = '0;
			id = int'(it.word[11:8]);
			mode = it.word[4:2];
			mask = it.word[1:0];
			ok = set_exists(id);
			case (it.cmd)
				CMD_TICK: begin
					for (int s = 0; s < NUM_LED_SETS; s++) begin
						if (tstate[s] != TMR_RUNNING)
							continue;
						if (remaining[s] <= 1)
							expire_timer(s);
						else
							remaining[s] = remaining[s] - 1'b1;
					end
				end
				CMD_SET_MODE: begin
					if (!ok) begin
						r.status = 1'b1;
					end else if (mode == MODE_OFF) begin
						halt_blink(id);
						go_dark(id);
					end else if (mode == MODE_ON) begin
						halt_blink(id);
						for (int c = 0; c < 2; c++) begin
							if (mask[c]) begin
								color_mode[id][c] = MODE_ON;
								lit[id][c] = 1'b1;
							end
						end
					end else if (mode <= MODE_VSLOW) begin
						go_dark(id);
						start_blinking(id, mask, mode_t'(mode));
					end
				end
				CMD_TOGGLE: begin
					if (!ok) begin
						r.status = 1'b1;
					end else begin
						for (int c = 0; c < 2; c++)
							if (mask[c])
								lit[id][c] ^= 1'b1;
					end
				end
				CMD_ALL_RED: begin
					for (int s = 0; s < NUM_LED_SETS; s++) begin
						if (set_exists(s)) begin
							go_dark(s);
							color_mode[s][COLOR_RED] = MODE_ON;
							lit[s][COLOR_RED] = 1'b1;
						end
					end
				end
				CMD_ALL_OFF: begin
					for (int s = 0; s < NUM_LED_SETS; s++)
						if (set_exists(s))
							go_dark(s);
				end
				default: ;
			endcase
			for (int s = 0; s < NUM_LED_SETS; s++) begin
				if (set_exists(s)) begin
					r.red[s] = lit[s][COLOR_RED];
					r.green[s] = lit[s][COLOR_GREEN];
				end
			end
			expected_leds.push_back(r);
		endfunction

		function void flag(string what, int exp_val, int got_val);
			errors++;
			if (errors <= 10)
				$display("%0t: mismatch on %s, expected %0h, got %0h",
					$realtime, what, exp_val, got_val);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] tdata);
			led_result_t got, want;
			got = tdata[12:0];
			if (expected_leds.size() == 0) begin
				flag("unexpected result", 0, int'(got));
				return;
			end
			want = expected_leds.pop_front();
			if (got.status !== want.status)
				flag("status", want.status, got.status);
			if (got.red !== want.red)
				flag("red_outputs", want.red, got.red);
			if (got.green !== want.green)
				flag("green_outputs", want.green, got.green);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [CMD_W-1:0]     s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PERIOD_W-1:0]  cfg_data;

	blink_scoreboard sb = new();

	// sender burst state, shared by the driving tasks
	int burst_left;
	int no_gaps_left;
	// asks the receiver for one long hold-off
	bit hold_request;

	multi_led_blink_controller #(
		.NUM_SETS   (NUM_LED_SETS),
		.TIMER_BITS (PERIOD_W)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// input transfers feed the model, output transfers get checked
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_item('{cmd: s_axis_tuser, word: s_axis_tdata[WORD_W-1:0]});
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// receiver: runs of random stall density, plus one long hold-off on request
	initial begin : rx_side
		int run_left;
		int stall_pct;
		int hold_left;
		m_axis_tready = 1'b0;
		run_left = 0;
		stall_pct = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = $urandom_range(120, 60);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(60, 5);
					case ($urandom_range(4, 0))
						0: stall_pct = 0;
						1: stall_pct = 10;
						2: stall_pct = 30;
						3: stall_pct = 60;
						default: stall_pct = 85;
					endcase
				end
				run_left--;
				m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
			end
		end
	end

	// run limit, far beyond the slowest legal run
	initial begin : run_limit
		#2_000_000;
		$display("FAIL multi_led_blink_controller");
		$finish;
	end

	function automatic led_item_t make_item(logic [CMD_W-1:0] cmd, int id,
			logic [MODE_W-1:0] mode, logic [1:0] mask);
		led_item_t it;
		it.cmd = cmd;
		it.word = {SET_ID_W'(id), 3'b000, mode, mask};
		return it;
	endfunction

	// mostly well-formed commands on existing sets, some noise
	function automatic led_item_t random_item(int tick_pct);
		led_item_t           it;
		int                  pick;
		logic [SET_ID_W-1:0] id;
		logic [MODE_W-1:0]   mode;
		if ($urandom_range(4, 0) == 0)
			id = SET_ID_W'($urandom_range(SET_ID_SPACE - 1, NUM_LED_SETS));
		else
			id = SET_ID_W'($urandom_range(NUM_LED_SETS - 1, 0));
		if ($urandom_range(9, 0) == 0)
			mode = MODE_W'($urandom_range(MODE_RSVD_HI, MODE_RSVD_LO));
		else
			mode = MODE_W'($urandom_range(MODE_VSLOW, MODE_OFF));
		it.word = {id, 3'($urandom), mode, 2'($urandom)};
		if ($urandom_range(99, 0) < 3)
			it.word = WORD_W'($urandom);
		if ($urandom_range(99, 0) < tick_pct) begin
			it.cmd = CMD_TICK;
		end else begin
			pick = $urandom_range(99, 0);
			if (pick < 62)
				it.cmd = CMD_SET_MODE;
			else if (pick < 80)
				it.cmd = CMD_TOGGLE;
			else if (pick < 86)
				it.cmd = CMD_ALL_RED;
			else if (pick < 92)
				it.cmd = CMD_ALL_OFF;
			else
				it.cmd = CMD_W'($urandom_range(7, CMD_RSVD_LO));
		end
		return it;
	endfunction

	// one item transfer; a gap may open before a new burst
	task automatic send_item(led_item_t it);
		@(negedge clk);
		if (burst_left == 0) begin
			if ($urandom_range(3, 0) == 0)
				burst_left = $urandom_range(150, 60);
			else
				burst_left = $urandom_range(30, 1);
			if (no_gaps_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(6, 1)) @(negedge clk);
			end
		end
		burst_left--;
		if (no_gaps_left > 0)
			no_gaps_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(S_TDATA_W - WORD_W){1'b0}}, it.word};
		s_axis_tuser <= it.cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// sender goes quiet until every predicted result is out
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (PIPE_LATENCY + 1) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [PERIOD_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_regs(logic [PERIOD_W-1:0] slow, logic [PERIOD_W-1:0] fast,
			logic [PERIOD_W-1:0] von, logic [PERIOD_W-1:0] voff,
			logic [LED_W-1:0] present, logic [LED_W-1:0] sync);
		write_reg(CFG_SLOW_HALF, slow);
		write_reg(CFG_FAST_HALF, fast);
		write_reg(CFG_VSLOW_ON, von);
		write_reg(CFG_VSLOW_OFF, voff);
		write_reg(CFG_PRESENT, PERIOD_W'(present));
		write_reg(CFG_SYNC_GROUP, PERIOD_W'(sync));
	endtask

	initial begin : main
		int n_items;
		int tick_pct;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 0;
		no_gaps_left = 0;
		hold_request = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// short periods so the directed part sees expiries
		program_regs(16'd3, 16'd2, 16'd2, 16'd4, 6'h3f, 6'h0f);

		// directed opening
		send_item(make_item(CMD_SET_MODE, 0, MODE_ON, MASK_BOTH));
		// on with empty mask lights nothing
		send_item(make_item(CMD_SET_MODE, 1, MODE_ON, MASK_NONE));
		send_item(make_item(CMD_SET_MODE, 2, MODE_SLOW, MASK_RED));
		// blink with empty mask falls back to green
		send_item(make_item(CMD_SET_MODE, 3, MODE_FAST, MASK_NONE));
		send_item(make_item(CMD_SET_MODE, 0, MODE_VSLOW, MASK_GREEN));
		// second group member pulls set 0 back into phase
		send_item(make_item(CMD_SET_MODE, 1, MODE_VSLOW, MASK_GREEN));
		// set outside the sync group still arms its own timer
		send_item(make_item(CMD_SET_MODE, 5, MODE_VSLOW, MASK_BOTH));
		repeat (5) send_item(make_item(CMD_TICK, 0, MODE_OFF, MASK_NONE));
		send_item(make_item(CMD_TOGGLE, 2, MODE_OFF, MASK_BOTH));
		// index past the last set, and past the set count
		send_item(make_item(CMD_TOGGLE, SET_ID_SPACE - 1, MODE_OFF, MASK_RED));
		send_item(make_item(CMD_SET_MODE, NUM_LED_SETS, MODE_ON, MASK_BOTH));
		send_item(make_item(CMD_SET_MODE, 4, MODE_RSVD_HI, MASK_BOTH));
		send_item('{cmd: CMD_W'(7), word: {WORD_W{1'b1}}});
		send_item(make_item(CMD_ALL_RED, 0, MODE_OFF, MASK_NONE));
		send_item(make_item(CMD_TICK, 0, MODE_OFF, MASK_NONE));
		// all off leaves timers running
		send_item(make_item(CMD_ALL_OFF, 0, MODE_OFF, MASK_NONE));
		repeat (3) send_item(make_item(CMD_TICK, 0, MODE_OFF, MASK_NONE));
		send_item(make_item(CMD_SET_MODE, 2, MODE_OFF, MASK_BOTH));

		// random phases, each under its own register setting
		for (int ph = 0; ph < 5; ph++) begin
			settle();
			case (ph)
				0: program_regs(16'd1, 16'd1, 16'd1, 16'd1, 6'h3f, 6'h3f);
				1: program_regs(16'd5, 16'd2, 16'd3, 16'd7, 6'h2d, 6'h0f);
				2: program_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 6'h00, 6'h00);
				default: program_regs(PERIOD_W'($urandom_range(12, 1)),
					PERIOD_W'($urandom_range(6, 1)), PERIOD_W'($urandom_range(8, 1)),
					PERIOD_W'($urandom_range(16, 1)), LED_W'($urandom),
					LED_W'($urandom));
			endcase
			n_items = (ph == 2) ? 120 : 330;
			tick_pct = (ph == 1 || ph == 3) ? 60 : 48;
			for (int k = 0; k < n_items; k++) begin
				// long output stall while the sender keeps pushing
				if (k == n_items / 3) begin
					hold_request = 1'b1;
					no_gaps_left = 40;
				end
				// sender pause until every result is back
				if (k == (2 * n_items) / 3)
					settle();
				send_item(random_item(tick_pct));
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS multi_led_blink_controller");
		end else begin
			$display("FAIL multi_led_blink_controller");
		end
		$finish;
	end

endmodule
